### sv/gif_lzw_encoder_unit_macros.svh
// ----------------------------------------------------------------------------
// GIF LZW encoder assertion macros
// Short forms for the concurrent checks used in the encoder RTL.
// ----------------------------------------------------------------------------
`ifndef GIF_LZW_ENCODER_UNIT_MACROS_SVH
`define GIF_LZW_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication under the active-low synchronous reset
`define GLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under the active-low synchronous reset
`define GLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/gle_pkg.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder package
// Sequencer states and fixed constants of the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package gle_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_W      = 4;
    localparam int HASH_SHIFT = 4;
    localparam int HV_W       = PIX_W + HASH_SHIFT;

    localparam logic [CFG_W-1:0] SIZE_MIN = 4'd2;
    localparam logic [CFG_W-1:0] SIZE_MAX = 4'd8;
    localparam logic [CFG_W-1:0] SIZE_RST = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_HASH,
        S_RD,
        S_CMP,
        S_MISS,
        S_INS,
        S_PUT_LD,
        S_PUT,
        S_SWEEP,
        S_POST,
        S_FIN_EOF,
        S_PAD,
        S_FLUSH
    } t_state;

endpackage

`default_nettype wire

### sv/gle_dict_ram.sv
// ----------------------------------------------------------------------------
// GIF LZW dictionary RAM
// Single write port, single registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module gle_dict_ram #(
    parameter int DEPTH  = 5003,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 33
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/gif_lzw_encoder_unit.sv
// ----------------------------------------------------------------------------
// GIF LZW encoder unit
// Colour indices in, LSB-first packed variable-width LZW bytes out.
// ----------------------------------------------------------------------------
//  channel   | dir | tdata               | tlast       | tuser
//  s_axis    | in  | [7:0] pixel_index   | final_pixel | -
//  m_axis    | out | [7:0] out_byte      | run_end     | [0] stream_end
//  i_cfg_*   | in  | [3:0] min_code_size (write only)
//
//  Pixels are taken only at idle; a first-probe hit then passes through the
//  hash, read, compare, post and flush states. Each further probe adds a read
//  and a compare, a miss adds the miss and insert states, and each emitted
//  code adds a load, a put per byte and a closing put. The first pixel of an
//  image and every table reset sweep all HASH_SLOTS RAM slots. Reset is
//  synchronous; a stalled output holds the sequencer on its next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module gif_lzw_encoder_unit
    import gle_pkg::*;
#(
    parameter int HASH_SLOTS    = 5003,
    parameter int MAX_CODE_BITS = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [CFG_W-1:0] i_cfg_wr_data,  // [3:0] min_code_size
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [PIX_W-1:0] s_axis_tdata,   // [7:0] pixel_index
    input  wire logic             s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser    // [0] stream_end
);

    `include "gif_lzw_encoder_unit_macros.svh"

    localparam int IDX_W  = $clog2(HASH_SLOTS);
    localparam int CODE_W = MAX_CODE_BITS;
    localparam int LIM_W  = MAX_CODE_BITS + 1;
    localparam int KEY_W  = PIX_W + MAX_CODE_BITS;
    localparam int DATA_W = 1 + KEY_W + CODE_W;
    localparam int ACC_W  = MAX_CODE_BITS + 7;
    localparam int N_W    = $clog2(MAX_CODE_BITS + 8);

    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(HASH_SLOTS - 1);
    localparam logic [IDX_W-1:0] SLOTS_C   = IDX_W'(HASH_SLOTS);
    localparam logic [3:0]       CW_MAX    = 4'(MAX_CODE_BITS);

    t_state r_state, n_state, r_ret, n_ret;

    logic [CFG_W-1:0]  r_cfg, n_cfg, r_as, n_as;
    logic [PIX_W-1:0]  r_pix, n_pix, r_c, n_c;
    logic              r_fin, n_fin;
    logic [IDX_W-1:0]  r_idx, n_idx, r_disp, n_disp, r_tries, n_tries;
    logic [IDX_W-1:0]  r_sweep, n_sweep;
    logic              r_second, n_second;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CODE_W-1:0] r_prefix, n_prefix, r_code, n_code;
    logic [LIM_W-1:0]  r_nfc, n_nfc, r_limit, n_limit;
    logic [3:0]        r_cw, n_cw;
    logic              r_cp, n_cp, r_started, n_started;
    logic [7:0]        r_bitbuf, n_bitbuf;
    logic [2:0]        r_bc, n_bc;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [N_W-1:0]    r_n, n_n;
    logic              r_hold_vld, n_hold_vld;
    logic [7:0]        r_hold, n_hold;
    logic              r_out_vld, n_out_vld, r_out_last, n_out_last;
    logic              r_out_user, n_out_user;
    logic [7:0]        r_out_byte, n_out_byte;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata, ram_rdata;

    logic              out_free, push_ok, push_go;
    logic [7:0]        push_b;
    logic [CFG_W-1:0]  sat_size;
    logic [PIX_W-1:0]  pmask;
    logic [CODE_W-1:0] clear_code, cmask;
    logic [HV_W-1:0]   hv;
    logic              rd_vld, rd_match, rd_key0;
    logic [KEY_W-1:0]  rd_key;
    logic [CODE_W-1:0] rd_code;
    logic [IDX_W-1:0]  disp_now, idx_next;

    gle_dict_ram #(
        .DEPTH  (HASH_SLOTS),
        .ADDR_W (IDX_W),
        .DATA_W (DATA_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_vld   = ram_rdata[DATA_W-1];
    assign rd_key   = ram_rdata[CODE_W +: KEY_W];
    assign rd_code  = ram_rdata[CODE_W-1:0];
    assign rd_match = rd_vld && (rd_key == r_key);
    assign rd_key0  = (rd_key == '0);

    assign out_free = !r_out_vld || m_axis_tready;
    assign push_ok  = !r_hold_vld || out_free;

    assign sat_size   = (r_cfg < SIZE_MIN) ? SIZE_MIN :
                        (r_cfg > SIZE_MAX) ? SIZE_MAX : r_cfg;
    assign pmask      = PIX_W'((9'd1 << r_as) - 9'd1);
    assign clear_code = CODE_W'(1) << r_as;
    assign cmask      = CODE_W'((32'd1 << r_cw) - 32'd1);
    assign hv         = {r_c, HASH_SHIFT'(0)} ^ HV_W'(r_prefix);
    assign disp_now   = r_second ? r_disp : ((r_idx == '0) ? IDX_W'(1) : SLOTS_C - r_idx);
    assign idx_next   = (r_idx >= disp_now) ? r_idx - disp_now : r_idx + SLOTS_C - disp_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_IDLE;
            r_cfg      <= SIZE_RST;
            r_as       <= SIZE_RST;
            r_prefix   <= '0;
            r_nfc      <= '0;
            r_cw       <= '0;
            r_limit    <= '0;
            r_cp       <= 1'b0;
            r_bitbuf   <= '0;
            r_bc       <= '0;
            r_started  <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ret      <= n_ret;
            r_cfg      <= n_cfg;
            r_as       <= n_as;
            r_prefix   <= n_prefix;
            r_nfc      <= n_nfc;
            r_cw       <= n_cw;
            r_limit    <= n_limit;
            r_cp       <= n_cp;
            r_bitbuf   <= n_bitbuf;
            r_bc       <= n_bc;
            r_started  <= n_started;
            r_hold_vld <= n_hold_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix      <= n_pix;
        r_fin      <= n_fin;
        r_c        <= n_c;
        r_idx      <= n_idx;
        r_disp     <= n_disp;
        r_tries    <= n_tries;
        r_second   <= n_second;
        r_sweep    <= n_sweep;
        r_key      <= n_key;
        r_code     <= n_code;
        r_acc      <= n_acc;
        r_n        <= n_n;
        r_hold     <= n_hold;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
        r_out_user <= n_out_user;
    end

    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        n_cfg      = i_cfg_wr_en ? i_cfg_wr_data : r_cfg;
        n_as       = r_as;
        n_pix      = r_pix;
        n_fin      = r_fin;
        n_c        = r_c;
        n_idx      = r_idx;
        n_disp     = r_disp;
        n_tries    = r_tries;
        n_second   = r_second;
        n_sweep    = r_sweep;
        n_key      = r_key;
        n_prefix   = r_prefix;
        n_code     = r_code;
        n_nfc      = r_nfc;
        n_cw       = r_cw;
        n_limit    = r_limit;
        n_cp       = r_cp;
        n_bitbuf   = r_bitbuf;
        n_bc       = r_bc;
        n_acc      = r_acc;
        n_n        = r_n;
        n_started  = r_started;
        n_hold_vld = r_hold_vld;
        n_hold     = r_hold;
        n_out_vld  = r_out_vld && !m_axis_tready;
        n_out_byte = r_out_byte;
        n_out_last = r_out_last;
        n_out_user = r_out_user;
        ram_we     = 1'b0;
        ram_waddr  = r_idx;
        ram_wdata  = {1'b1, r_key, r_nfc[CODE_W-1:0]};
        push_go    = 1'b0;
        push_b     = r_acc[7:0];
        s_axis_tready = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_pix   = s_axis_tdata;
                    n_fin   = s_axis_tlast;
                    n_c     = s_axis_tdata & pmask;
                    n_state = r_started ? S_HASH : S_START;
                end
            end
            S_START: begin
                n_as      = sat_size;
                n_cw      = sat_size + 4'd1;
                n_limit   = LIM_W'((32'd1 << (sat_size + 4'd1)) - 32'd1);
                n_nfc     = LIM_W'((32'd1 << sat_size) + 32'd2);
                n_cp      = 1'b0;
                n_bitbuf  = '0;
                n_bc      = '0;
                n_prefix  = CODE_W'(r_pix & PIX_W'((9'd1 << sat_size) - 9'd1));
                n_code    = CODE_W'(1) << sat_size;
                n_started = 1'b1;
                n_sweep   = '0;
                n_ret     = S_SWEEP;
                n_state   = S_PUT_LD;
            end
            S_HASH: begin
                n_idx    = IDX_W'(hv);
                n_key    = {r_c, r_prefix};
                n_second = 1'b0;
                n_tries  = '0;
                n_state  = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (rd_match) begin
                    n_prefix = rd_code;
                    n_state  = S_POST;
                end else if (!r_second && !rd_vld) begin
                    n_state = S_MISS;
                end else if (r_second && (!rd_vld || rd_key0 || r_tries == LAST_SLOT)) begin
                    n_state = S_MISS;
                end else begin
                    // step to the next slot of the secondary probe
                    n_disp   = disp_now;
                    n_tries  = r_second ? r_tries + IDX_W'(1) : '0;
                    n_second = 1'b1;
                    n_idx    = idx_next;
                    n_state  = S_RD;
                end
            end
            S_MISS: begin
                n_code  = r_prefix;
                n_ret   = S_INS;
                n_state = S_PUT_LD;
            end
            S_INS: begin
                n_prefix = CODE_W'(r_c);
                if (!r_nfc[LIM_W-1]) begin
                    ram_we  = 1'b1;
                    n_nfc   = r_nfc + LIM_W'(1);
                    n_state = S_POST;
                end else begin
                    // code space full: empty the table and send Clear
                    n_nfc   = LIM_W'(clear_code) + LIM_W'(2);
                    n_cp    = 1'b1;
                    n_code  = clear_code;
                    n_sweep = '0;
                    n_ret   = S_SWEEP;
                    n_state = S_PUT_LD;
                end
            end
            S_PUT_LD: begin
                n_acc   = ACC_W'(r_bitbuf) | (ACC_W'(r_code & cmask) << r_bc);
                n_n     = N_W'(r_bc) + N_W'(r_cw);
                n_state = S_PUT;
            end
            S_PUT: begin
                if (r_n >= N_W'(8)) begin
                    if (push_ok) begin
                        push_go = 1'b1;
                        n_acc   = r_acc >> 8;
                        n_n     = r_n - N_W'(8);
                    end
                end else begin
                    n_bitbuf = r_acc[7:0];
                    n_bc     = r_n[2:0];
                    if (r_cp) begin
                        n_cw    = r_as + 4'd1;
                        n_limit = LIM_W'((32'd1 << (r_as + 4'd1)) - 32'd1);
                        n_cp    = 1'b0;
                    end else if (r_nfc > r_limit) begin
                        n_cw = r_cw + 4'd1;
                        if (r_cw + 4'd1 == CW_MAX) begin
                            n_limit = LIM_W'(1) << MAX_CODE_BITS;
                        end else begin
                            n_limit = LIM_W'((32'd1 << (r_cw + 4'd1)) - 32'd1);
                        end
                    end
                    n_state = r_ret;
                end
            end
            S_SWEEP: begin
                ram_we    = 1'b1;
                ram_waddr = r_sweep;
                ram_wdata = '0;
                n_sweep   = r_sweep + IDX_W'(1);
                if (r_sweep == LAST_SLOT) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (r_fin) begin
                    n_code  = r_prefix;
                    n_ret   = S_FIN_EOF;
                    n_state = S_PUT_LD;
                end else begin
                    n_state = S_FLUSH;
                end
            end
            S_FIN_EOF: begin
                n_code  = clear_code + CODE_W'(1);
                n_ret   = S_PAD;
                n_state = S_PUT_LD;
            end
            S_PAD: begin
                push_b = r_bitbuf;
                if (r_bc == '0 || push_ok) begin
                    push_go   = (r_bc != '0);
                    n_bitbuf  = '0;
                    n_bc      = '0;
                    n_started = 1'b0;
                    n_state   = S_FLUSH;
                end
            end
            S_FLUSH: begin
                // release the held byte as the last of this transfer run
                if (!r_hold_vld) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_byte = r_hold;
                    n_out_last = 1'b1;
                    n_out_user = r_fin;
                    n_hold_vld = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (push_go) begin
            if (r_hold_vld) begin
                n_out_vld  = 1'b1;
                n_out_byte = r_hold;
                n_out_last = 1'b0;
                n_out_user = 1'b0;
            end
            n_hold     = push_b;
            n_hold_vld = 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_byte;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_user;

    `GLE_ASSERT_NOW(a_ins_room, i_clk, i_rst_n, ram_we && ram_wdata[DATA_W-1], !r_nfc[LIM_W-1], "dictionary insert with full code space")
    `GLE_ASSERT_NOW(a_cw_range, i_clk, i_rst_n, r_started && r_state != S_START, (r_cw >= 4'd3) && (r_cw <= CW_MAX), "code width out of range")
    `GLE_ASSERT_NOW(a_end_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "stream end without run end")
    `GLE_ASSERT_NOW(a_idle_hold, i_clk, i_rst_n, r_state == S_IDLE, !r_hold_vld, "held byte left at idle")
    `GLE_ASSERT_NEXT(a_put_drain, i_clk, i_rst_n, r_state == S_PUT_LD, r_n <= N_W'(MAX_CODE_BITS + 7), "packer bit count overflow")

endmodule

`default_nettype wire
